// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

// ----- design/tdps_pkg.sv -----
`default_nettype none
package tdps_pkg;
  localparam int NUM_THRUSTERS = 6;
  localparam int NumThrMax = 6;
  localparam int TimeW = 63;
  localparam int NsW = 40;
  localparam int ImpW = 32;
  localparam int ForceW = 32;
  localparam int RestW = 16;
  localparam int DivW = 62;
  localparam int DivCntW = 6;
  localparam logic [29:0] NsPerS = 30'd1000000000;
  localparam logic [NsW-1:0] Max40 = {NsW{1'b1}};
  localparam int InDataW = 256;
  localparam int OutDataW = 240;

  localparam logic [2:0] CfgRest = 3'd0;
  localparam logic [2:0] CfgMinFire = 3'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } lane_ctl_t;
endpackage
`default_nettype wire

// ----- design/tdps_lane.sv -----
`default_nettype none
`include "assert_macros.svh"
// One thruster: impulse to ns via a restoring divider, one quotient bit per cycle
module tdps_lane (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tdps_pkg::lane_ctl_t         ctl,
  input  wire logic [tdps_pkg::ImpW-1:0]   impulse,
  input  wire logic [tdps_pkg::ForceW-1:0] force_val,
  output logic [tdps_pkg::NsW-1:0]         quot,
  output logic                             done
);
  logic [tdps_pkg::DivW-1:0]    num_r, num_nxt;
  logic [tdps_pkg::DivW-1:0]    q_r, q_nxt;
  logic [tdps_pkg::ForceW:0]    rem_r, rem_nxt;
  logic [tdps_pkg::ForceW-1:0]  den_r, den_nxt;
  logic [tdps_pkg::DivCntW-1:0] cnt_r, cnt_nxt;
  logic                         neg_r, neg_nxt;
  logic                         run_r, run_nxt;
  logic [tdps_pkg::ForceW:0]    trial;
  logic [61:0]                  prod;

  assign prod = {31'd0, impulse[30:0]} * {32'd0, tdps_pkg::NsPerS};
  assign trial = {rem_r[tdps_pkg::ForceW-1:0], num_r[tdps_pkg::DivW-1]};

  always_comb begin
    num_nxt = num_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    run_nxt = run_r;
    if (ctl.start) begin
      num_nxt = prod;
      q_nxt = '0;
      rem_nxt = '0;
      den_nxt = force_val;
      neg_nxt = impulse[tdps_pkg::ImpW-1] || (impulse[tdps_pkg::ImpW-2:0] == '0);
      cnt_nxt = tdps_pkg::DivCntW'(tdps_pkg::DivW - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      num_nxt = {num_r[tdps_pkg::DivW-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[tdps_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[tdps_pkg::DivW-2:0], 1'b0};
      end
      if (cnt_r == '0) run_nxt = 1'b0;
      else cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
    num_r <= num_nxt;
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  // zero or negative impulse yields zero; zero divisor yields all ones in q, which saturates
  always_comb begin
    if (neg_r) quot = '0;
    else if (q_r[tdps_pkg::DivW-1:tdps_pkg::NsW] != '0) quot = tdps_pkg::Max40;
    else quot = q_r[tdps_pkg::NsW-1:0];
  end
  assign done = !run_r;

  `CHK_ASSERT(a_start_idle, ctl.start |-> !run_r, "lane started while busy")
  `CHK_ASSERT(a_run_busy, run_r |-> ctl.busy, "lane runs outside busy")
  `CHK_ASSERT(a_cnt_step, (run_r && $past(run_r) && !$past(ctl.start)) |-> (cnt_r == $past(cnt_r) - 1'b1), "lane count skipped")
endmodule
`default_nettype wire

// ----- design/tdps_merge.sv -----
`default_nettype none
// Select the on-times, clamp and update the remainders for all lanes
module tdps_merge (
  input  wire logic [tdps_pkg::NumThrMax-1:0][tdps_pkg::NsW-1:0] quot,
  input  wire logic [tdps_pkg::NumThrMax-1:0][tdps_pkg::NsW-1:0] remain,
  input  wire logic                                               req,
  input  wire logic                                               fire,
  input  wire logic [tdps_pkg::NsW-1:0]                           dt,
  input  wire logic [31:0]                                        min_fire,
  output logic [tdps_pkg::NumThrMax-1:0][tdps_pkg::NsW-1:0]       on_time,
  output logic [tdps_pkg::NumThrMax-1:0][tdps_pkg::NsW-1:0]       remain_nxt
);
  always_comb begin
    logic [tdps_pkg::NsW-1:0] t;
    for (int i = 0; i < tdps_pkg::NumThrMax; i++) begin
      t = req ? quot[i] : remain[i];
      remain_nxt[i] = remain[i];
      on_time[i] = '0;
      if (i < tdps_pkg::NUM_THRUSTERS && (req || fire)) begin
        remain_nxt[i] = (t > dt) ? t - dt : '0;
        if (t < {8'd0, min_fire}) on_time[i] = '0;
        else if (t > dt) on_time[i] = dt;
        else on_time[i] = t;
      end
    end
  end
endmodule
`default_nettype wire

// ----- design/thruster_dump_pulse_scheduler.sv -----
`default_nettype none
`include "assert_macros.svh"
// Thruster dump pulse scheduler. One input transaction is one control tick; one
// result transaction follows. A tick with new_request set, other than the first tick
// after reset, is worked between acceptance and result in six parallel bit-serial
// dividers (one quotient bit per cycle over a 62-bit numerator). Another tick is
// accepted once the previous result has been taken. Configuration writes must be
// made while no tick is in flight.
module thruster_dump_pulse_scheduler (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tick_time, impulse_0 .. impulse_5, zero fill
  input  wire logic [255:0] in_tdata,
  // new_request
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // on_time_0 .. on_time_5
  output logic [239:0]      out_tdata
);
  localparam int N = tdps_pkg::NumThrMax;

  tdps_pkg::state_t state_r, state_nxt;
  logic [15:0] rest_ticks_r, rest_count_r, rest_count_nxt;
  logic [31:0] min_fire_r;
  logic [N-1:0][31:0] force_r;
  logic started_r, started_nxt;
  logic [tdps_pkg::TimeW-1:0] prior_r, prior_nxt;
  logic [N-1:0][tdps_pkg::NsW-1:0] remain_r, remain_nxt, quot, on_time;
  logic [tdps_pkg::NsW-1:0] dt_r, dt_nxt;
  logic req_r, req_nxt, act_r, act_nxt;
  logic [N-1:0] lane_done;
  tdps_pkg::lane_ctl_t ctl;
  logic [239:0] out_r;
  logic out_load;
  logic [tdps_pkg::TimeW-1:0] now, diff;

  assign now = in_tdata[tdps_pkg::TimeW-1:0];
  assign diff = now - prior_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_ticks_r <= '0;
      min_fire_r <= '0;
      for (int i = 0; i < N; i++) force_r[i] <= 32'd1000000;
    end else if (cfg_we) begin
      case (cfg_index)
        tdps_pkg::CfgRest: rest_ticks_r <= cfg_data[15:0];
        tdps_pkg::CfgMinFire: min_fire_r <= cfg_data;
        default: force_r[cfg_index - 3'd2] <= cfg_data;
      endcase
    end
  end

  assign in_tready = (state_r == tdps_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    started_nxt = started_r;
    prior_nxt = prior_r;
    dt_nxt = dt_r;
    req_nxt = req_r;
    act_nxt = act_r;
    ctl.start = 1'b0;
    ctl.busy = (state_r == tdps_pkg::ST_DIV);
    out_load = 1'b0;
    rest_count_nxt = rest_count_r;
    case (state_r)
      tdps_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          act_nxt = started_r;
          req_nxt = in_tuser;
          started_nxt = 1'b1;
          prior_nxt = now;
          if (now <= prior_r) dt_nxt = '0;
          else if (diff[tdps_pkg::TimeW-1:tdps_pkg::NsW] != '0) dt_nxt = tdps_pkg::Max40;
          else dt_nxt = diff[tdps_pkg::NsW-1:0];
          ctl.start = in_tuser && started_r;
          state_nxt = tdps_pkg::ST_DIV;
        end
      end
      tdps_pkg::ST_DIV: begin
        if (&lane_done) begin
          out_load = 1'b1;
          state_nxt = tdps_pkg::ST_OUT;
          if (act_r) begin
            if (req_r || rest_count_r == '0) rest_count_nxt = rest_ticks_r;
            else rest_count_nxt = rest_count_r - 1'b1;
          end
        end
      end
      tdps_pkg::ST_OUT: begin
        if (out_tready) state_nxt = tdps_pkg::ST_IDLE;
      end
      default: state_nxt = tdps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdps_pkg::ST_IDLE;
      started_r <= 1'b0;
      prior_r <= '0;
      rest_count_r <= '0;
      remain_r <= '0;
    end else begin
      state_r <= state_nxt;
      started_r <= started_nxt;
      prior_r <= prior_nxt;
      rest_count_r <= rest_count_nxt;
      if (out_load && act_r) remain_r <= remain_nxt;
    end
    dt_r <= dt_nxt;
    req_r <= req_nxt;
    act_r <= act_nxt;
    if (out_load) out_r <= act_r ? on_time : '0;
  end

  for (genvar g = 0; g < N; g++) begin : g_lane
    tdps_lane u_lane (
      .clk(clk), .rst_n(rst_n), .ctl(ctl),
      .impulse(in_tdata[tdps_pkg::TimeW + 32*g +: 32]),
      .force_val(force_r[g]),
      .quot(quot[g]), .done(lane_done[g])
    );
  end

  tdps_merge u_merge (
    .quot(quot), .remain(remain_r), .req(req_r),
    .fire(rest_count_r == '0), .dt(dt_r), .min_fire(min_fire_r),
    .on_time(on_time), .remain_nxt(remain_nxt)
  );

  assign out_tvalid = (state_r == tdps_pkg::ST_OUT);
  assign out_tdata = out_r;

  `CHK_ASSERT(a_out_after_div, $rose(out_tvalid) |-> $past(&lane_done), "result before divide done")
  `CHK_ASSERT(a_hold_out, (out_tvalid && !out_tready) |=> $stable(out_tdata), "result changed under stall")
  `CHK_ASSERT(a_no_overlap, (in_tvalid && in_tready) |-> !out_tvalid, "tick accepted with result pending")
endmodule
`default_nettype wire
